### rtl/wsd_pkg.sv
// shared types, opcodes and helpers for the websocket frame deframer
package wsd_pkg;

  // frame opcodes
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;

  // result kinds
  localparam logic [2:0] KindText  = 3'd0;
  localparam logic [2:0] KindBin   = 3'd1;
  localparam logic [2:0] KindClose = 3'd2;
  localparam logic [2:0] KindPing  = 3'd3;

  localparam logic [15:0] CloseDefault = 16'd1000;

  // one work request from the header parser to the output stage
  typedef struct packed {
    logic       data_valid;
    logic [7:0] raw_byte;
    logic [7:0] mask_byte;
    logic       first;
    logic       frame_end;
    logic       message_end;
    logic       abort_prev;
    logic [2:0] kind;
    logic       is_close;
  } cmd_t;

  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    unique case (op)
      OpText:  k = KindText;
      OpBin:   k = KindBin;
      OpClose: k = KindClose;
      default: k = KindPing;
    endcase
    return k;
  endfunction

endpackage

### rtl/wsd_front.sv
// header parser: walks frame headers, tracks length and mask, issues requests
module wsd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [7:0]    rx_byte_i,
  output logic          push_o,
  output wsd_pkg::cmd_t cmd_o
);

  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhPayAbrt = 3'd5;
  localparam logic [2:0] PhDrop    = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;
  logic [1:0]  open_q, open_d;
  logic        first_q, first_d;

  logic        do_start;
  logic [63:0] len_cur;
  logic [63:0] rem_dec;
  logic        pay_end;
  logic [3:0]  eff_op;
  logic        deliver;
  logic        abort;
  logic [1:0]  idx_inc;

  assign rem_dec = rem_q - 64'd1;
  assign pay_end = (rem_dec == 64'd0);
  assign idx_inc = idx_q + 2'd1;

  always_comb begin
    phase_d   = phase_q;
    ext_cnt_d = ext_cnt_q;
    fin_d     = fin_q;
    op_d      = op_q;
    masked_d  = masked_q;
    rem_d     = rem_q;
    key_d     = key_q;
    idx_d     = idx_q;
    open_d    = open_q;
    first_d   = first_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    do_start  = 1'b0;
    len_cur   = rem_q;
    eff_op    = op_q;
    deliver   = 1'b0;
    abort     = 1'b0;

    if (in_fire_i) begin
      unique case (phase_q)
        PhHdr1: begin
          masked_d = rx_byte_i[7];
          if (rx_byte_i[6:0] == 7'd126) begin
            rem_d     = '0;
            ext_cnt_d = 3'd1;
            phase_d   = PhExtLen;
          end else if (rx_byte_i[6:0] == 7'd127) begin
            rem_d     = '0;
            ext_cnt_d = 3'd7;
            phase_d   = PhExtLen;
          end else begin
            len_cur = {57'd0, rx_byte_i[6:0]};
            rem_d   = len_cur;
            if (rx_byte_i[7]) begin
              idx_d   = 2'd0;
              phase_d = PhMask;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        PhExtLen: begin
          len_cur = {rem_q[55:0], rx_byte_i};
          rem_d   = len_cur;
          if (ext_cnt_q == 3'd0) begin
            if (masked_q) begin
              idx_d   = 2'd0;
              phase_d = PhMask;
            end else begin
              do_start = 1'b1;
            end
          end else begin
            ext_cnt_d = ext_cnt_q - 3'd1;
          end
        end
        PhMask: begin
          key_d = {key_q[23:0], rx_byte_i};
          idx_d = idx_inc;
          if (idx_inc == 2'd0) begin
            do_start = 1'b1;
          end
        end
        PhPayload, PhPayAbrt: begin
          push_o            = 1'b1;
          cmd_o.data_valid  = 1'b1;
          cmd_o.raw_byte    = rx_byte_i;
          // ~idx picks key byte 3 - idx, first key byte sits on top
          cmd_o.mask_byte   = masked_q ? key_q[{~idx_q, 3'b000} +: 8] : 8'd0;
          cmd_o.first       = first_q;
          cmd_o.frame_end   = pay_end;
          cmd_o.message_end = pay_end && fin_q
                              && (op_q == wsd_pkg::OpText || op_q == wsd_pkg::OpBin);
          cmd_o.abort_prev  = (phase_q == PhPayAbrt);
          cmd_o.kind        = wsd_pkg::kind_of(op_q);
          cmd_o.is_close    = (op_q == wsd_pkg::OpClose);
          idx_d             = idx_inc;
          rem_d             = rem_dec;
          first_d           = 1'b0;
          phase_d           = pay_end ? PhHdr0 : PhPayload;
        end
        PhDrop: begin
          rem_d = rem_dec;
          if (pay_end) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PhHdr1;
        end
      endcase
    end

    // header complete: classify the frame
    if (do_start) begin
      idx_d = 2'd0;
      if (op_q == wsd_pkg::OpCont) begin
        if (open_q != 2'd0) begin
          eff_op  = {2'b00, open_q};
          deliver = 1'b1;
          if (fin_q) begin
            open_d = 2'd0;
          end
        end
      end else if (op_q == wsd_pkg::OpText || op_q == wsd_pkg::OpBin) begin
        if (!fin_q) begin
          abort  = (open_q != 2'd0);
          open_d = op_q[1:0];
        end
        deliver = 1'b1;
      end else if (op_q == wsd_pkg::OpClose || op_q == wsd_pkg::OpPing) begin
        deliver = 1'b1;
      end

      if (!deliver) begin
        phase_d = (len_cur != 64'd0) ? PhDrop : PhHdr0;
      end else begin
        op_d = eff_op;
        if (len_cur == 64'd0) begin
          push_o            = 1'b1;
          cmd_o.first       = 1'b1;
          cmd_o.frame_end   = 1'b1;
          cmd_o.message_end = fin_q
                              && (eff_op == wsd_pkg::OpText || eff_op == wsd_pkg::OpBin);
          cmd_o.abort_prev  = abort;
          cmd_o.kind        = wsd_pkg::kind_of(eff_op);
          cmd_o.is_close    = (eff_op == wsd_pkg::OpClose);
          phase_d           = PhHdr0;
        end else begin
          first_d = 1'b1;
          phase_d = abort ? PhPayAbrt : PhPayload;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHdr0;
      ext_cnt_q <= '0;
      fin_q     <= 1'b0;
      op_q      <= '0;
      masked_q  <= 1'b0;
      rem_q     <= '0;
      key_q     <= '0;
      idx_q     <= '0;
      open_q    <= '0;
      first_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ext_cnt_q <= ext_cnt_d;
      fin_q     <= fin_d;
      op_q      <= op_d;
      masked_q  <= masked_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
      open_q    <= open_d;
      first_q   <= first_d;
    end
  end

endmodule

### rtl/wsd_queue.sv
// short request queue between header parser and output stage
module wsd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output wsd_pkg::cmd_t pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  wsd_pkg::cmd_t   mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/wsd_back.sv
// output stage: unmasks payload, collects close status, holds the result register
module wsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  wsd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,
  output logic [2:0]    m_axis_tuser,
  output logic          m_axis_tlast
);

  logic        out_valid_q, out_valid_d;
  logic [31:0] data_q, data_d;
  logic [2:0]  user_q;
  logic        last_q;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  seen_q, seen_d;

  logic [7:0]  plain;
  logic [15:0] acc_cur;
  logic [1:0]  seen_cur;
  logic [15:0] close_code;
  logic        disc;

  assign pop_o = cmd_valid_i && (!out_valid_q || m_axis_tready);

  always_comb begin
    plain    = cmd_i.raw_byte ^ cmd_i.mask_byte;
    // status bytes restart with each frame
    acc_cur  = cmd_i.first ? 16'd0 : acc_q;
    seen_cur = cmd_i.first ? 2'd0 : seen_q;
    acc_d    = acc_cur;
    seen_d   = seen_cur;
    if (cmd_i.data_valid && cmd_i.is_close && seen_cur < 2'd2) begin
      acc_d  = {acc_cur[7:0], plain};
      seen_d = seen_cur + 2'd1;
    end
    disc       = cmd_i.frame_end && cmd_i.is_close;
    close_code = disc ? ((seen_d == 2'd2) ? acc_d : wsd_pkg::CloseDefault) : 16'd0;
    data_d     = {4'd0, disc, close_code, cmd_i.abort_prev, cmd_i.message_end,
                  cmd_i.data_valid ? plain : 8'd0, cmd_i.data_valid};

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      seen_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        acc_q  <= acc_d;
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= cmd_i.kind;
      last_q <= cmd_i.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

### rtl/websocket_frame_deframer_unit.sv
// websocket frame deframer top level: parser, request queue, output stage
//
//  channel   dir  payload
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tdata: data_valid, data_byte, message_end, abort_prev,
//                 close_code, disconnect_req; tuser kind; tlast frame_end
//
// one byte per cycle sustained while m_axis does not stall; the header parser
// decides each byte in the cycle it is taken and writes its request into the
// queue at that edge, and the output stage pops it from the queue into its
// result register when that register is free or m_axis_tready is high.
// s_axis_tready drops only while the request queue is full, which happens
// when m_axis stalls; the parser then waits with its state held.
// reset is asynchronous, active low, and starts at the first header byte.
module websocket_frame_deframer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] data_valid, [8:1] data_byte, [9] message_end, [10] abort_prev,
  // [26:11] close_code, [27] disconnect_req, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // frame_end
);

  logic          q_full;
  logic          in_fire;
  logic          push;
  wsd_pkg::cmd_t push_cmd;
  logic          pop;
  logic          q_valid;
  wsd_pkg::cmd_t pop_cmd;

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && !q_full;

  wsd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .rx_byte_i (s_axis_tdata),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  wsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  wsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/wsd_result_check.sv
// result checker for the websocket frame deframer: predicts each result and compares it
`timescale 1ns / 100ps
module wsd_result_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  typedef enum logic [2:0] {
    PhHdr0, PhHdr1, PhExtLen, PhMask, PhPayload, PhPayloadAbort, PhDrop
  } parse_phase_e;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [2:0]  kind;
    logic        frame_end;
    logic        message_end;
    logic        abort_prev;
    logic [15:0] close_code;
    logic        disconnect_req;
  } ws_result_t;

  parse_phase_e phase;
  logic [2:0]   ext_left;
  logic         hdr_fin;
  logic [3:0]   hdr_op;
  logic         hdr_masked;
  logic [63:0]  bytes_left;
  logic [31:0]  key;
  logic [1:0]   key_pos;
  logic [1:0]   open_kind;   // 0 none, else low bits of the text or binary opcode
  logic [15:0]  close_acc;
  logic [1:0]   close_seen;

  ws_result_t   expected_results[$];
  int unsigned  mismatches;

  function automatic ws_result_t make_result(input logic valid, input logic [7:0] b,
                                             input logic last, input logic abort);
    ws_result_t r;
    r.data_valid  = valid;
    r.data_byte   = valid ? b : 8'h00;
    case (hdr_op)
      wsd_pkg::OpText:  r.kind = wsd_pkg::KindText;
      wsd_pkg::OpBin:   r.kind = wsd_pkg::KindBin;
      wsd_pkg::OpClose: r.kind = wsd_pkg::KindClose;
      default:          r.kind = wsd_pkg::KindPing;
    endcase
    r.frame_end   = last;
    r.message_end = last && hdr_fin
                    && (hdr_op == wsd_pkg::OpText || hdr_op == wsd_pkg::OpBin);
    r.abort_prev  = abort;
    r.close_code  = 16'h0000;
    if (last && hdr_op == wsd_pkg::OpClose) begin
      r.close_code = (close_seen >= 2'd2) ? close_acc : wsd_pkg::CloseDefault;
    end
    r.disconnect_req = last && (hdr_op == wsd_pkg::OpClose);
    return r;
  endfunction

  // header done: decide whether the payload is delivered, dropped or empty
  task automatic begin_payload();
    logic deliver;
    logic abort;
    deliver    = 1'b0;
    abort      = 1'b0;
    key_pos    = 2'd0;
    close_acc  = 16'h0000;
    close_seen = 2'd0;
    case (hdr_op)
      wsd_pkg::OpCont: begin
        if (open_kind != 2'd0) begin
          hdr_op = {2'b00, open_kind};
          if (hdr_fin) open_kind = 2'd0;
          deliver = 1'b1;
        end
      end
      wsd_pkg::OpText, wsd_pkg::OpBin: begin
        if (!hdr_fin) begin
          abort     = (open_kind != 2'd0);
          open_kind = hdr_op[1:0];
        end
        deliver = 1'b1;
      end
      wsd_pkg::OpClose, wsd_pkg::OpPing: deliver = 1'b1;
      default: ;
    endcase
    if (!deliver) begin
      phase = (bytes_left != 64'd0) ? PhDrop : PhHdr0;
    end else if (bytes_left == 64'd0) begin
      expected_results.push_back(make_result(1'b0, 8'h00, 1'b1, abort));
      phase = PhHdr0;
    end else begin
      phase = abort ? PhPayloadAbort : PhPayload;
    end
  endtask

  task automatic length_known();
    if (hdr_masked) begin
      key_pos = 2'd0;
      phase   = PhMask;
    end else begin
      begin_payload();
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0] d;
    logic       last;
    logic       abort;
    case (phase)
      PhHdr1: begin
        hdr_masked = b[7];
        bytes_left = 64'd0;
        if (b[6:0] == 7'd126) begin
          ext_left = 3'd1;
          phase    = PhExtLen;
        end else if (b[6:0] == 7'd127) begin
          ext_left = 3'd7;
          phase    = PhExtLen;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          length_known();
        end
      end
      PhExtLen: begin
        bytes_left = {bytes_left[55:0], b};
        if (ext_left == 3'd0) length_known();
        else ext_left = ext_left - 3'd1;
      end
      PhMask: begin
        key     = {key[23:0], b};
        key_pos = key_pos + 2'd1;
        if (key_pos == 2'd0) begin_payload();
      end
      PhPayload, PhPayloadAbort: begin
        abort = (phase == PhPayloadAbort);
        d     = b;
        if (hdr_masked) d = b ^ key[8 * (3 - int'(key_pos)) +: 8];
        key_pos = key_pos + 2'd1;
        if (hdr_op == wsd_pkg::OpClose && close_seen < 2'd2) begin
          close_acc  = {close_acc[7:0], d};
          close_seen = close_seen + 2'd1;
        end
        bytes_left = bytes_left - 64'd1;
        last       = (bytes_left == 64'd0);
        expected_results.push_back(make_result(1'b1, d, last, abort));
        phase = last ? PhHdr0 : PhPayload;
      end
      PhDrop: begin
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 64'd0) phase = PhHdr0;
      end
      default: begin
        hdr_fin = b[7];
        hdr_op  = b[3:0];
        phase   = PhHdr1;
      end
    endcase
  endtask

  task automatic compare_result();
    ws_result_t got;
    ws_result_t want;
    got.data_valid     = m_axis_tdata[0];
    got.data_byte      = m_axis_tdata[8:1];
    got.kind           = m_axis_tuser;
    got.frame_end      = m_axis_tlast;
    got.message_end    = m_axis_tdata[9];
    got.abort_prev     = m_axis_tdata[10];
    got.close_code     = m_axis_tdata[26:11];
    got.disconnect_req = m_axis_tdata[27];
    if (expected_results.size() == 0) begin
      if (mismatches < 10) $display("unexpected result: %p", got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
          got.kind !== want.kind || got.frame_end !== want.frame_end ||
          got.message_end !== want.message_end || got.abort_prev !== want.abort_prev ||
          got.close_code !== want.close_code || got.disconnect_req !== want.disconnect_req ||
          m_axis_tdata[31:28] !== 4'h0) begin
        if (mismatches < 10) begin
          $display("result mismatch at %0t: expected %p", $realtime, want);
          $display("  actual %p, tdata %h", got, m_axis_tdata);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = PhHdr0;
      ext_left   = 3'd0;
      hdr_fin    = 1'b0;
      hdr_op     = wsd_pkg::OpCont;
      hdr_masked = 1'b0;
      bytes_left = 64'd0;
      key        = 32'd0;
      key_pos    = 2'd0;
      open_kind  = 2'd0;
      close_acc  = 16'h0000;
      close_seen = 2'd0;
      expected_results.delete();
    end else begin
      // results first, so a request taken in this cycle never matches itself
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata);
    end
    pending_count_o  = expected_results.size();
    mismatch_count_o = mismatches;
  end

endmodule

### tb/tb_top.sv
// testbench top for the websocket frame deframer: clock, reset, frame stimulus, verdict
`timescale 1ns / 100ps
module tb_top;

  localparam logic [3:0] OpPong     = 4'hA;
  localparam logic [3:0] OpReserved = 4'h3;
  localparam int unsigned LenShort  = 0;
  localparam int unsigned LenMid    = 1;
  localparam int unsigned LenLong   = 2;
  localparam int unsigned RandomBytes = 900;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned bytes_sent;
  bit          quiet;   // no idling on either side while set

  always #1 clk_i = ~clk_i;

  websocket_frame_deframer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  wsd_result_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
  end

  // called at a falling edge, returns at the falling edge after the byte is taken
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr0, input logic masked, input logic [63:0] len,
                            input int unsigned len_form, input int unsigned body_bytes,
                            input bit extremes);
    logic [7:0] b;
    send_byte(hdr0);
    case (len_form)
      LenShort: send_byte({masked, len[6:0]});
      LenMid: begin
        send_byte({masked, 7'd126});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, 7'd127});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < body_bytes; i++) begin
      b = extremes ? ((i % 2 == 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  // mostly well-formed frames with random content, some garbage headers
  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned form;
    logic [3:0]  op;
    logic        fin;
    logic        masked;
    logic [7:0]  hdr0;
    pick   = $urandom_range(0, 99);
    fin    = 1'($urandom_range(0, 1));
    masked = 1'($urandom_range(0, 1));
    if (pick < 30) op = wsd_pkg::OpCont;
    else if (pick < 50) op = wsd_pkg::OpText;
    else if (pick < 70) op = wsd_pkg::OpBin;
    else if (pick < 78) op = wsd_pkg::OpClose;
    else if (pick < 86) op = wsd_pkg::OpPing;
    else if (pick < 91) op = OpPong;
    else op = 4'($urandom_range(0, 15));
    hdr0 = {fin, 3'b000, op};
    if (pick >= 91) hdr0 = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 0;
    else if (pick <= 7) len = $urandom_range(1, 12);
    else if (pick == 8) len = $urandom_range(13, 125);
    else len = $urandom_range(126, 300);
    pick = $urandom_range(0, 19);
    if (len >= 126) form = (pick < 15) ? LenMid : LenLong;
    else if (pick < 17) form = LenShort;
    else if (pick < 19) form = LenMid;
    else form = LenLong;
    send_frame(hdr0, masked, 64'(len), form, len, 1'b0);
  endtask

  initial begin
    int unsigned start;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    quiet         = 1'b0;
    bytes_sent    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty frame
    send_frame({1'b1, 3'b000, wsd_pkg::OpText}, 1'b0, 64'd0, LenShort, 0, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpText}, 1'b1, 64'd4, LenShort, 4, 1'b1);
    // opens binary
    send_frame({1'b0, 3'b000, wsd_pkg::OpBin}, 1'b0, 64'd1, LenShort, 1, 1'b0);
    // final text mid-message
    send_frame({1'b1, 3'b000, wsd_pkg::OpText}, 1'b1, 64'd2, LenShort, 2, 1'b0);
    // abandons binary
    send_frame({1'b0, 3'b000, wsd_pkg::OpText}, 1'b0, 64'd2, LenShort, 2, 1'b1);
    send_frame({1'b0, 3'b000, wsd_pkg::OpCont}, 1'b1, 64'd1, LenShort, 1, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpCont}, 1'b0, 64'd0, LenShort, 0, 1'b0);
    // orphan continuation
    send_frame({1'b1, 3'b000, wsd_pkg::OpCont}, 1'b0, 64'd2, LenShort, 2, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpClose}, 1'b0, 64'd0, LenShort, 0, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpClose}, 1'b0, 64'd1, LenShort, 1, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpClose}, 1'b1, 64'd3, LenShort, 3, 1'b0);
    // reserved bits set
    send_frame({1'b0, 3'b111, wsd_pkg::OpPing}, 1'b0, 64'd1, LenShort, 1, 1'b1);
    send_frame({1'b1, 3'b000, OpPong}, 1'b0, 64'd2, LenShort, 2, 1'b0);
    send_frame({1'b1, 3'b000, OpReserved}, 1'b1, 64'd1, LenShort, 1, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpBin}, 1'b1, 64'd0, LenMid, 0, 1'b0);
    send_frame({1'b1, 3'b000, wsd_pkg::OpBin}, 1'b0, 64'd2, LenLong, 2, 1'b1);

    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      quiet = (bytes_sent - start >= 300) && (bytes_sent - start < 450);
      random_frame();
    end
    quiet = 1'b0;

    // 64-bit length with the top bit set: only the first payload bytes are sent
    send_frame({1'b1, 3'b000, wsd_pkg::OpBin}, 1'b1, 64'h8000_0000_0000_0005, LenLong, 3,
               1'b0);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule
